FILE: rtl/ufsc_pkg.sv
// ----------------------------------------------------------------------------
// ufsc_pkg
// Shared types, constants and the crc-16 byte update for the frame deframer.
// ----------------------------------------------------------------------------
package ufsc_pkg;

	// frame geometry
	localparam int FRAME_LEN    = 14;
	localparam int POS_W        = 4;
	localparam int ADDR_POS     = 1;
	localparam int CMD_POS      = 2;
	localparam int PAYLOAD_LAST = 10;
	localparam int CRC_LOW_POS  = 11;
	localparam int CRC_HIGH_POS = 12;

	// crc-16/modbus
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// configuration register indexes and reset values
	localparam logic REG_START_CHAR = 1'b0;
	localparam logic REG_STOP_CHAR  = 1'b1;
	localparam logic [7:0] START_CHAR_RESET = 8'd60;
	localparam logic [7:0] STOP_CHAR_RESET  = 8'd62;

	// result status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_NO_ALIGN = 2'd1;
	localparam logic [1:0] STATUS_CRC_ERR  = 2'd2;

	// commands from controller to datapath
	typedef struct packed {
		logic wr;
		logic scan;
		logic walk;
		logic load;
	} ufsc_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic last;
		logic found;
		logic walk_done;
		logic out_free;
	} ufsc_sts_t;

	// one byte through the reflected crc, bit by bit
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			if (c[0])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

endpackage

FILE: rtl/uart_frame_sync_crc_check.sv
// ----------------------------------------------------------------------------
// uart_frame_sync_crc_check
// Fixed-length frame deframer: 14-byte window, alignment on start/stop
// characters, crc-16/modbus check, frame fields out.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | rx_byte
//  out     | output    | out_valid / out_stall| status, frame_address,
//          |           |                      | frame_command, frame_payload
//  cfg     | input     | cfg_write            | cfg_index, cfg_data
//
//  bytes 1..13 of a window are taken while idle; the 14th adds a scan, a walk
//  over the 12 bytes after the start (one byte per cycle, bytes 1..10 through
//  the crc) and a load; in_stall stays high until the load; a miss skips the walk.
//  reset clears the fill count, the controller, out_valid and sets the start
//  and stop characters to '<' and '>'; window contents are not cleared.
//  bytes are still taken while a result beat waits; only the load waits on it.
// ----------------------------------------------------------------------------
module uart_frame_sync_crc_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [7:0]  frame_address,
	output logic [7:0]  frame_command,
	output logic [63:0] frame_payload
);
	import ufsc_pkg::*;

	ufsc_cmd_t cmd;
	ufsc_sts_t sts;

	// controller
	ufsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	ufsc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.rx_byte       (rx_byte),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.frame_address (frame_address),
		.frame_command (frame_command),
		.frame_payload (frame_payload)
	);

endmodule

FILE: rtl/ufsc_ctrl.sv
// ----------------------------------------------------------------------------
// ufsc_ctrl
// Controller: collects bytes, then sequences the alignment scan, the byte
// walk through the crc and the hand-over to the output register.
// ----------------------------------------------------------------------------
module ufsc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  ufsc_pkg::ufsc_sts_t  sts,
	output ufsc_pkg::ufsc_cmd_t  cmd
);
	import ufsc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_WALK   = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t state_q, state_d;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.wr = 1'b1;
					if (sts.last)
						state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				state_d  = sts.found ? ST_WALK : ST_FINISH;
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
				if (sts.walk_done)
					state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// last byte of a window always starts a scan
	a_last_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid && sts.last) |=> (state_q == ST_SCAN))
		else $error("window complete but no scan");

	// walk ends in finish
	a_walk_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && sts.walk_done) |=> (state_q == ST_FINISH))
		else $error("walk did not end in finish");

	// state stays one-hot
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state not one-hot");

endmodule

FILE: rtl/ufsc_dp.sv
// ----------------------------------------------------------------------------
// ufsc_dp
// Datapath: byte window, alignment scan, crc walk, config registers and the
// output register.
// ----------------------------------------------------------------------------
module ufsc_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ufsc_pkg::ufsc_cmd_t  cmd,
	output ufsc_pkg::ufsc_sts_t  sts,
	input  logic [7:0]           rx_byte,
	input  logic                 cfg_write,
	input  logic                 cfg_index,
	input  logic [7:0]           cfg_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status,
	output logic [7:0]           frame_address,
	output logic [7:0]           frame_command,
	output logic [63:0]          frame_payload
);
	import ufsc_pkg::*;

	logic [7:0]       win_q [FRAME_LEN];
	logic [POS_W-1:0] fill_q;
	logic [7:0]       start_char_q, stop_char_q;

	logic [POS_W-1:0] begin_q, k_q;
	logic             found_q;
	logic [15:0]      crc_q, got_q;
	logic [7:0]       addr_q, cmdb_q;
	logic [63:0]      pay_q;

	logic             out_valid_q;
	logic [1:0]       status_q;
	logic [7:0]       address_q, command_q;
	logic [63:0]      payload_q;

	logic [FRAME_LEN-1:0] match;
	logic                 aligned, found_c;
	logic [POS_W-1:0]     begin_c;
	logic [POS_W:0]       idx_sum, idx_mod;
	logic [7:0]           rd_byte;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_char_q <= START_CHAR_RESET;
			stop_char_q  <= STOP_CHAR_RESET;
		end else if (cfg_write) begin
			if (cfg_index == REG_START_CHAR)
				start_char_q <= cfg_data;
			else
				stop_char_q <= cfg_data;
		end
	end

	// fill position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fill_q <= '0;
		else if (cmd.wr)
			fill_q <= (fill_q == POS_W'(FRAME_LEN - 1)) ? '0 : fill_q + 1'b1;
	end

	// window write
	always_ff @(posedge clk) begin
		if (cmd.wr)
			win_q[fill_q] <= rx_byte;
	end

	// alignment scan: aligned test first, else first start after a stop
	always_comb begin
		match   = '0;
		aligned = (win_q[0] == start_char_q) && (win_q[FRAME_LEN-1] == stop_char_q);
		for (int i = 1; i < FRAME_LEN; i++)
			match[i] = (win_q[i] == start_char_q) && (win_q[i-1] == stop_char_q);
		found_c = aligned || (|match);
		begin_c = '0;
		if (!aligned) begin
			for (int i = FRAME_LEN - 1; i >= 1; i--) begin
				if (match[i])
					begin_c = POS_W'(i);
			end
		end
	end

	// rotated read address, wraps once at most
	always_comb begin
		idx_sum = {1'b0, begin_q} + {1'b0, k_q};
		if (idx_sum >= (POS_W+1)'(FRAME_LEN))
			idx_mod = idx_sum - (POS_W+1)'(FRAME_LEN);
		else
			idx_mod = idx_sum;
		rd_byte = win_q[idx_mod[POS_W-1:0]];
	end

	// scan result and byte walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			k_q     <= '0;
		end else if (cmd.scan) begin
			found_q <= found_c;
			k_q     <= POS_W'(ADDR_POS);
		end else if (cmd.walk) begin
			k_q <= k_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			begin_q <= begin_c;
			crc_q   <= CRC_INIT;
		end else if (cmd.walk) begin
			if (k_q <= POS_W'(PAYLOAD_LAST))
				crc_q <= crc_byte(crc_q, rd_byte);
			if (k_q == POS_W'(ADDR_POS))
				addr_q <= rd_byte;
			else if (k_q == POS_W'(CMD_POS))
				cmdb_q <= rd_byte;
			else if (k_q <= POS_W'(PAYLOAD_LAST))
				pay_q <= {rd_byte, pay_q[63:8]};
			else if (k_q == POS_W'(CRC_LOW_POS))
				got_q[7:0] <= rd_byte;
			else
				got_q[15:8] <= rd_byte;
		end
	end

	// output register, control part
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	// output register, payload part
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (!found_q) begin
				status_q  <= STATUS_NO_ALIGN;
				address_q <= '0;
				command_q <= '0;
				payload_q <= '0;
			end else begin
				status_q  <= (crc_q == got_q) ? STATUS_OK : STATUS_CRC_ERR;
				address_q <= addr_q;
				command_q <= cmdb_q;
				payload_q <= pay_q;
			end
		end
	end

	// status to controller
	always_comb begin
		sts.last      = (fill_q == POS_W'(FRAME_LEN - 1));
		sts.found     = found_c;
		sts.walk_done = (k_q == POS_W'(CRC_HIGH_POS));
		sts.out_free  = !out_valid_q || !out_stall;
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign frame_address = address_q;
	assign frame_command = command_q;
	assign frame_payload = payload_q;

	// a load always presents a beat next cycle
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> out_valid_q)
		else $error("load did not raise out_valid");

	// a held beat is never overwritten by a load
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !cmd.load)
		else $error("load over a stalled beat");

	// no-alignment beats carry zero fields
	a_no_align_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == STATUS_NO_ALIGN) |->
		(address_q == 8'd0 && command_q == 8'd0 && payload_q == 64'd0))
		else $error("no-alignment beat with non-zero fields");

	// window is never written during a scan or walk
	a_no_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan || cmd.walk) |-> !cmd.wr)
		else $error("window written while busy");

endmodule
